// ----- hw/rtl/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the alphabet lookup shared by the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int JOB_Q_DEPTH = 2;
  localparam int JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int JOB_CHARS   = 4;
  localparam int JOB_IDX_W   = $clog2(JOB_CHARS);

  // Position within the three-byte group.
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_end;
  } out_word_t;

  // Characters one byte produces, the index of its last one, and whether
  // that last character closes the message.
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [JOB_IDX_W-1:0]      last_idx;
    logic                      fin;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the group phase and leftover bits, and turns each byte into a job
// of one to four characters.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  b64e_pkg::in_word_t in_data,
  output b64e_pkg::job_t    job
);
  import b64e_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       fin;

  assign b   = in_data.in_byte;
  assign fin = in_data.in_end;

  always_comb begin
    job       = '0;
    job.fin   = fin;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    unique case (phase_r)
      PHASE_SECOND: begin
        job.chars[0] = b64_char({carry_r[1:0], b[7:4]});
        if (fin) begin
          job.chars[1] = b64_char({b[3:0], 2'b00});
          job.chars[2] = PAD_CHAR;
          job.last_idx = JOB_IDX_W'(2);
        end else begin
          job.last_idx = JOB_IDX_W'(0);
          carry_nxt    = b[3:0];
          phase_nxt    = PHASE_THIRD;
        end
      end
      PHASE_THIRD: begin
        job.chars[0] = b64_char({carry_r, b[7:6]});
        job.chars[1] = b64_char(b[5:0]);
        job.last_idx = JOB_IDX_W'(1);
        carry_nxt    = 4'd0;
        phase_nxt    = PHASE_FIRST;
      end
      default: begin
        // The unused phase code behaves as the start of a group.
        job.chars[0] = b64_char(b[7:2]);
        if (fin) begin
          job.chars[1] = b64_char({b[1:0], 4'b0000});
          job.chars[2] = PAD_CHAR;
          job.chars[3] = PAD_CHAR;
          job.last_idx = JOB_IDX_W'(3);
        end else begin
          job.last_idx = JOB_IDX_W'(0);
          carry_nxt    = {2'b00, b[1:0]};
          phase_nxt    = PHASE_SECOND;
        end
      end
    endcase
    if (fin) begin
      phase_nxt = PHASE_FIRST;
      carry_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_FIRST;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64e_job_queue.sv -----
// ----------------------------------------------------------------------------
// b64e_job_queue
// Short first-in first-out queue of character jobs between front and back.
// ----------------------------------------------------------------------------
module b64e_job_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  b64e_pkg::job_t  wr_job,
  output logic            q_full,
  input  logic            rd_en,
  output b64e_pkg::job_t  rd_job,
  output logic            q_valid
);
  import b64e_pkg::*;

  job_t                 mem [JOB_Q_DEPTH];
  logic [JOB_Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_Q_PTR_W:0]   count_r;

  assign q_full  = (count_r == (JOB_Q_PTR_W+1)'(JOB_Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_job  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == JOB_Q_PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == JOB_Q_PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// Walks the characters of the head job into the output register, one per
// cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  b64e_pkg::job_t     job,
  output logic               job_done,
  output logic               empty,
  input  logic               pop,
  output b64e_pkg::out_word_t out_data
);
  import b64e_pkg::*;

  logic [JOB_IDX_W-1:0] pos_r;
  logic                 out_valid_r;
  out_word_t            out_r;
  logic                 load;
  logic                 at_last;

  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign load     = job_valid && (!out_valid_r || pop);
  assign at_last  = (pos_r == job.last_idx);
  assign job_done = load && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.out_char <= job.chars[pos_r];
      out_r.out_end  <= job.fin && at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r       <= at_last ? '0 : pos_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a word (one message byte plus a flag on
// the final byte) is taken on a clock edge with push high and full low.
// Output side is a queue read port: while empty is low, out_data holds the
// oldest character, and it is taken on an edge with pop high.
// The front classifies each byte by its place in the three-byte group and
// builds one to four characters; a two-entry job queue separates it from the
// back, which sends one character per cycle through an output register while the receiver pops.
// The first character of a byte passes through the job queue and then the
// output register. Throughput is set by the single-character output port:
// one character per cycle while the receiver pops. Bytes are taken every
// cycle while the job queue has room.
// The last character of a message carries out_end.
// Synchronous reset clears the group phase and empties the queue and output register.
// When the receiver stalls, the output holds, the queue fills, and full
// rises until characters drain again.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  b64e_pkg::in_word_t  in_data,
  output logic                empty,
  input  logic                pop,
  output b64e_pkg::out_word_t out_data
);
  import b64e_pkg::*;

  logic accept;
  job_t new_job;
  job_t head_job;
  logic head_valid;
  logic head_done;

  assign accept = push && !full;

  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .job     (new_job)
  );

  b64e_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_job  (new_job),
    .q_full  (full),
    .rd_en   (head_done),
    .rd_job  (head_job),
    .q_valid (head_valid)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job       (head_job),
    .job_done  (head_done),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
